// ===== rtl/tpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpc_pkg: shared types and constants for the triangle plane clipper
// Vertex, distance and queue entry types, register indexes and reset values.
// ----------------------------------------------------------------------------
package tpc_pkg;

   localparam int CoordWidth  = 32;
   localparam int NormWidth   = 16;
   localparam int ColourWidth = 24;
   localparam int DistWidth   = 52;
   localparam int ProdWidth   = NormWidth + CoordWidth;
   localparam int FracBits    = 30;
   localparam int DataWidth   = 9 * CoordWidth + ColourWidth;
   localparam int CsrIdxWidth = 3;
   localparam int CsrWidth    = 32;
   localparam int QueueDepthDefault = 2;

   localparam logic [CsrIdxWidth-1:0] CSR_NORMAL_X     = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_NORMAL_Y     = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_NORMAL_Z     = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_PLANE_OFFSET = 3'd3;

   localparam logic signed [NormWidth-1:0]  NormalXReset = 16'sd0;
   localparam logic signed [NormWidth-1:0]  NormalYReset = 16'sd0;
   localparam logic signed [NormWidth-1:0]  NormalZReset = 16'sd16384;
   localparam logic signed [CsrWidth-1:0]   OffsetReset  = 32'sd6554;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [DistWidth-1:0]  dist_type;
   typedef logic [FracBits-1:0]          frac_type;

   // x sits in the lowest bits so that three vertices pack straight into tdata
   typedef struct packed {
      coord_type z;
      coord_type y;
      coord_type x;
   } vert_type;

   typedef enum logic [1:0] {
      MODE_ALL,
      MODE_ONE,
      MODE_TWO
   } mode_type;

   // Cut 0 runs from p0 to q0, cut 1 from p1 to q1; MODE_ALL keeps a, b, c in p0, p1, q0
   typedef struct packed {
      mode_type                 mode;
      vert_type                 p0;
      vert_type                 p1;
      vert_type                 q0;
      vert_type                 q1;
      dist_type                 dp0;
      dist_type                 dq0;
      dist_type                 dp1;
      dist_type                 dq1;
      logic [ColourWidth-1:0]   colour;
   } entry_type;

endpackage

// ===== rtl/tpc_front.sv =====
// ----------------------------------------------------------------------------
// tpc_front: plane registers, distance pipeline and classification
// Two stages: products, then sums and sort into cut roles; pushes the queue.
// ----------------------------------------------------------------------------
module tpc_front import tpc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrWidth-1:0]     csr_wdata,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [DataWidth-1:0]    req_tdata,
   output logic                    push,
   output entry_type               push_entry,
   input  logic                    queue_full
);

   logic signed [NormWidth-1:0] nx_ff, ny_ff, nz_ff;
   logic signed [CsrWidth-1:0]  off_ff;

   logic                   s1_valid_ff;
   vert_type [2:0]         s1_vert_ff;
   logic [ColourWidth-1:0] s1_colour_ff;
   logic signed [ProdWidth-1:0] s1_prod_ff [3][3];
   logic signed [ProdWidth-1:0] s1_prod_in [3][3];

   logic                   s2_valid_ff;
   entry_type              s2_entry_ff, s2_entry_in;
   logic                   s2_drop_in;

   logic                   s1_adv, s2_adv;
   vert_type [2:0]         in_vert;
   dist_type [2:0]         vert_dist;
   logic [2:0]             is_in;

   // Write plane registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff  <= NormalXReset;
         ny_ff  <= NormalYReset;
         nz_ff  <= NormalZReset;
         off_ff <= OffsetReset;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NORMAL_X:     nx_ff  <= csr_wdata[NormWidth-1:0];
            CSR_NORMAL_Y:     ny_ff  <= csr_wdata[NormWidth-1:0];
            CSR_NORMAL_Z:     nz_ff  <= csr_wdata[NormWidth-1:0];
            CSR_PLANE_OFFSET: off_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance each stage when the next one can take its contents
   assign s2_adv     = !s2_valid_ff || !queue_full;
   assign s1_adv     = !s1_valid_ff || s2_adv;
   assign req_tready = s1_adv;
   assign push       = s2_valid_ff && !queue_full;
   assign push_entry = s2_entry_ff;

   assign in_vert = req_tdata[9*CoordWidth-1:0];

   // Form the nine normal-by-coordinate products
   always_comb begin
      for (int v = 0; v < 3; v++) begin
         s1_prod_in[v][0] = nx_ff * in_vert[v].x;
         s1_prod_in[v][1] = ny_ff * in_vert[v].y;
         s1_prod_in[v][2] = nz_ff * in_vert[v].z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s1_valid_ff <= req_tvalid;
      end
      if (s1_adv) begin
         s1_vert_ff   <= in_vert;
         s1_colour_ff <= req_tdata[DataWidth-1:9*CoordWidth];
         s1_prod_ff   <= s1_prod_in;
      end
   end

   // Sum into signed distances; zero or more is inside
   always_comb begin
      for (int v = 0; v < 3; v++) begin
         vert_dist[v] = DistWidth'(s1_prod_ff[v][0]) + DistWidth'(s1_prod_ff[v][1])
                      + DistWidth'(s1_prod_ff[v][2])
                      - (DistWidth'(off_ff) <<< 14);
         is_in[v] = !vert_dist[v][DistWidth-1];
      end
   end

   // Sort vertices into cut roles, keeping input order
   always_comb begin
      s2_entry_in        = '0;
      s2_entry_in.colour = s1_colour_ff;
      s2_drop_in         = 1'b0;
      case (is_in)
         3'b111: begin
            s2_entry_in.mode = MODE_ALL;
            s2_entry_in.p0 = s1_vert_ff[0];
            s2_entry_in.p1 = s1_vert_ff[1];
            s2_entry_in.q0 = s1_vert_ff[2];
         end
         3'b001, 3'b010, 3'b100: begin
            s2_entry_in.mode = MODE_ONE;
            for (int v = 0; v < 3; v++) begin
               if (is_in[v]) begin
                  s2_entry_in.p0  = s1_vert_ff[v];
                  s2_entry_in.p1  = s1_vert_ff[v];
                  s2_entry_in.dp0 = vert_dist[v];
                  s2_entry_in.dp1 = vert_dist[v];
               end
            end
            s2_entry_in.q0  = is_in[0] ? s1_vert_ff[1] : s1_vert_ff[0];
            s2_entry_in.dq0 = is_in[0] ? vert_dist[1] : vert_dist[0];
            s2_entry_in.q1  = is_in[2] ? s1_vert_ff[1] : s1_vert_ff[2];
            s2_entry_in.dq1 = is_in[2] ? vert_dist[1] : vert_dist[2];
         end
         3'b011, 3'b101, 3'b110: begin
            s2_entry_in.mode = MODE_TWO;
            s2_entry_in.p0  = is_in[0] ? s1_vert_ff[0] : s1_vert_ff[1];
            s2_entry_in.dp0 = is_in[0] ? vert_dist[0] : vert_dist[1];
            s2_entry_in.p1  = is_in[2] ? s1_vert_ff[2] : s1_vert_ff[1];
            s2_entry_in.dp1 = is_in[2] ? vert_dist[2] : vert_dist[1];
            for (int v = 0; v < 3; v++) begin
               if (!is_in[v]) begin
                  s2_entry_in.q0  = s1_vert_ff[v];
                  s2_entry_in.q1  = s1_vert_ff[v];
                  s2_entry_in.dq0 = vert_dist[v];
                  s2_entry_in.dq1 = vert_dist[v];
               end
            end
         end
         default: begin
            s2_drop_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         s2_valid_ff <= s1_valid_ff && !s2_drop_in;
      end
      if (s2_adv) begin
         s2_entry_ff <= s2_entry_in;
      end
   end

endmodule

// ===== rtl/tpc_queue.sv =====
// ----------------------------------------------------------------------------
// tpc_queue: small queue of classified triangles
// Decouples the distance pipeline from the cut engine.
// ----------------------------------------------------------------------------
module tpc_queue import tpc_pkg::*; #(
   parameter int DEPTH = QueueDepthDefault
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output entry_type head
);

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);

   entry_type             mem_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CntWidth-1:0]   count_ff;

   assign full      = count_ff == CntWidth'(DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = mem_ff[rd_ptr_ff];

   // Store on push
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Move pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CntWidth'(push) - CntWidth'(pop);
      end
   end

endmodule

// ===== rtl/tpc_div.sv =====
// ----------------------------------------------------------------------------
// tpc_div: restoring divider for the edge fraction
// Forms dp / (dp - dq) as a Q0.30 fraction, one bit per cycle.
// ----------------------------------------------------------------------------
module tpc_div import tpc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  dist_type dp,
   input  dist_type dq,
   output logic     busy,
   output frac_type quot
);

   localparam int RemWidth = DistWidth + 1;
   localparam int CntWidth = $clog2(FracBits + 1);

   logic [RemWidth-1:0] rem_ff, den_ff, rem_shift;
   logic [CntWidth-1:0] cnt_ff;
   frac_type            quot_ff;

   assign busy      = cnt_ff != '0;
   assign quot      = quot_ff;
   assign rem_shift = {rem_ff[RemWidth-2:0], 1'b0};

   // Shift, compare, subtract
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CntWidth'(FracBits);
      end else if (busy) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (start) begin
         rem_ff  <= RemWidth'(dp);
         den_ff  <= RemWidth'(dp) - {dq[DistWidth-1], dq};
         quot_ff <= '0;
      end else if (busy) begin
         if (rem_shift >= den_ff) begin
            rem_ff  <= rem_shift - den_ff;
            quot_ff <= {quot_ff[FracBits-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_shift;
            quot_ff <= {quot_ff[FracBits-2:0], 1'b0};
         end
      end
   end

endmodule

// ===== rtl/tpc_back.sv =====
// ----------------------------------------------------------------------------
// tpc_back: cut engine and result register
// Divides, scales and rounds both cut points of a cut triangle, then emits one or two triangles.
// ----------------------------------------------------------------------------
module tpc_back import tpc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 not_empty,
   input  entry_type            head,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DataWidth-1:0] rsp_tdata,
   output logic                 rsp_tlast
);

   localparam int MulWidth = 2 * CoordWidth;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_RND,
      ST_OUT1,
      ST_OUT2
   } state_type;

   state_type            state_ff;
   entry_type            work_ff;
   vert_type             c0_ff, c1_ff;
   logic signed [MulWidth-1:0] prod_ff [2][3];
   logic                 rsp_valid_ff;
   logic [DataWidth-1:0] rsp_data_ff;
   logic                 rsp_last_ff;

   logic                 start;
   logic                 busy0, busy1;
   frac_type             t0, t1;
   logic                 out_free;
   logic                 out_load;
   logic signed [CoordWidth:0] diff [2][3];
   coord_type            rnd [2][3];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign out_load   = out_free && (state_ff == ST_OUT1 || state_ff == ST_OUT2);
   assign pop        = state_ff == ST_IDLE && not_empty;
   assign start      = pop && head.mode != MODE_ALL;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   tpc_div u_div0 (
      .clock (clock), .reset (reset), .start (start),
      .dp (head.dp0), .dq (head.dq0), .busy (busy0), .quot (t0)
   );

   tpc_div u_div1 (
      .clock (clock), .reset (reset), .start (start),
      .dp (head.dp1), .dq (head.dq1), .busy (busy1), .quot (t1)
   );

   // Edge deltas, outside minus inside
   always_comb begin
      diff[0][0] = {work_ff.q0.x[CoordWidth-1], work_ff.q0.x}
                 - {work_ff.p0.x[CoordWidth-1], work_ff.p0.x};
      diff[0][1] = {work_ff.q0.y[CoordWidth-1], work_ff.q0.y}
                 - {work_ff.p0.y[CoordWidth-1], work_ff.p0.y};
      diff[0][2] = {work_ff.q0.z[CoordWidth-1], work_ff.q0.z}
                 - {work_ff.p0.z[CoordWidth-1], work_ff.p0.z};
      diff[1][0] = {work_ff.q1.x[CoordWidth-1], work_ff.q1.x}
                 - {work_ff.p1.x[CoordWidth-1], work_ff.p1.x};
      diff[1][1] = {work_ff.q1.y[CoordWidth-1], work_ff.q1.y}
                 - {work_ff.p1.y[CoordWidth-1], work_ff.p1.y};
      diff[1][2] = {work_ff.q1.z[CoordWidth-1], work_ff.q1.z}
                 - {work_ff.p1.z[CoordWidth-1], work_ff.p1.z};
   end

   // Round to nearest at 2^-30, ties up; floor by arithmetic shift
   always_comb begin
      logic signed [MulWidth-1:0] biased;
      biased = '0;
      for (int c = 0; c < 2; c++) begin
         for (int k = 0; k < 3; k++) begin
            biased    = prod_ff[c][k] + (MulWidth'(1) <<< (FracBits - 1));
            rnd[c][k] = CoordWidth'(biased >>> FracBits);
         end
      end
   end

   // Sequence one triangle: load, divide, scale, round, emit; a fully inside triangle goes straight to emit
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (not_empty) begin
                  state_ff <= (head.mode == MODE_ALL) ? ST_OUT1 : ST_DIV;
               end
            end
            ST_DIV: begin
               if (!busy0 && !busy1) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: state_ff <= ST_RND;
            ST_RND: state_ff <= ST_OUT1;
            ST_OUT1: begin
               if (out_free) begin
                  state_ff <= (work_ff.mode == MODE_TWO) ? ST_OUT2 : ST_IDLE;
               end
            end
            ST_OUT2: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end

      if (pop) begin
         work_ff <= head;
      end
      if (state_ff == ST_MUL) begin
         for (int k = 0; k < 3; k++) begin
            prod_ff[0][k] <= MulWidth'(diff[0][k]) * MulWidth'($signed({1'b0, t0}));
            prod_ff[1][k] <= MulWidth'(diff[1][k]) * MulWidth'($signed({1'b0, t1}));
         end
      end
      if (state_ff == ST_RND) begin
         c0_ff.x <= work_ff.p0.x + rnd[0][0];
         c0_ff.y <= work_ff.p0.y + rnd[0][1];
         c0_ff.z <= work_ff.p0.z + rnd[0][2];
         c1_ff.x <= work_ff.p1.x + rnd[1][0];
         c1_ff.y <= work_ff.p1.y + rnd[1][1];
         c1_ff.z <= work_ff.p1.z + rnd[1][2];
      end

      // Load the result register
      if (state_ff == ST_OUT1 && out_free) begin
         case (work_ff.mode)
            MODE_ALL: begin
               rsp_data_ff <= {work_ff.colour, work_ff.q0, work_ff.p1, work_ff.p0};
               rsp_last_ff <= 1'b1;
            end
            MODE_ONE: begin
               rsp_data_ff <= {work_ff.colour, c1_ff, c0_ff, work_ff.p0};
               rsp_last_ff <= 1'b1;
            end
            default: begin
               rsp_data_ff <= {work_ff.colour, c0_ff, work_ff.p1, work_ff.p0};
               rsp_last_ff <= 1'b0;
            end
         endcase
      end
      if (state_ff == ST_OUT2 && out_free) begin
         rsp_data_ff <= {work_ff.colour, c1_ff, c0_ff, work_ff.p1};
         rsp_last_ff <= 1'b1;
      end
   end

endmodule

// ===== rtl/triangle_plane_clipper.sv =====
// ----------------------------------------------------------------------------
// triangle_plane_clipper: clip one triangle against one configured plane
// Triangles enter on req_*, clipped triangles leave on rsp_* with rsp_tlast
// set on the final triangle of each input; csr_* writes the plane registers
// (normal x, y, z in Q2.14, offset in Q16.16). The user must write them only
// while the block is idle; the block itself does not enforce it. A two-stage
// distance pipeline classifies each triangle and pushes it into a short
// queue, so req_tready stays high until both stages and the queue are full
// behind a busy cut engine. Fully outside triangles are dropped in the front.
// Triangles fully inside skip the dividers; the cut engine takes the next
// triangle from the queue only once the current one has been emitted. A cut
// triangle holds the cut engine through load, the bit-serial divider steps
// (one per quotient bit), a check that the dividers have finished, one
// multiply, one round and the output; for a quad the second triangle
// follows the first.
// A stalled rsp_tready holds the result register, then the engine, then
// the queue, and finally drops req_tready. Reset (synchronous, active
// high) empties the pipeline and queue and restores the plane registers.
// ----------------------------------------------------------------------------
module triangle_plane_clipper import tpc_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CsrWidth-1:0]    csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, colour
   input  logic [DataWidth-1:0]   req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
   // out_c_x, out_c_y, out_c_z, out_colour
   output logic [DataWidth-1:0]   rsp_tdata,
   output logic                   rsp_tlast
);

   logic      push, full, pop, not_empty;
   entry_type push_entry, head;

   tpc_front u_front (
      .clock (clock), .reset (reset),
      .csr_we (csr_we), .csr_index (csr_index), .csr_wdata (csr_wdata),
      .req_tvalid (req_tvalid), .req_tready (req_tready), .req_tdata (req_tdata),
      .push (push), .push_entry (push_entry), .queue_full (full)
   );

   tpc_queue #(.DEPTH (QUEUE_DEPTH)) u_queue (
      .clock (clock), .reset (reset),
      .push (push), .push_entry (push_entry), .full (full),
      .pop (pop), .not_empty (not_empty), .head (head)
   );

   tpc_back u_back (
      .clock (clock), .reset (reset),
      .not_empty (not_empty), .head (head), .pop (pop),
      .rsp_tvalid (rsp_tvalid), .rsp_tready (rsp_tready),
      .rsp_tdata (rsp_tdata), .rsp_tlast (rsp_tlast)
   );

endmodule

// ===== test/tb_triangle_plane_clipper.sv =====
// ----------------------------------------------------------------------------
// tb_triangle_plane_clipper: self-checking bench for the triangle plane clipper
// Drives triangles on req_*, predicts the clipped triangles from the plane
// registers with exact wide arithmetic, and checks every rsp_* transaction in
// order. Plane registers are rewritten between test phases while idle.
// ----------------------------------------------------------------------------
module tb_triangle_plane_clipper;
   timeunit 1ns;
   timeprecision 1ps;

   import tpc_pkg::*;

   // an index past the last plane register
   localparam logic [CsrIdxWidth-1:0] CSR_UNUSED = 3'd5;

   typedef struct {
      logic [DataWidth-1:0] data;
      logic                 last;
   } tri_out_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [CsrWidth-1:0]    csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [DataWidth-1:0]   req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [DataWidth-1:0]   rsp_tdata;
   logic                   rsp_tlast;

   // plane copy used by the predictor
   logic signed [15:0] plane_nx, plane_ny, plane_nz;
   logic signed [31:0] plane_off;

   tri_out_type clipped_q[$];
   int  error_count = 0;
   int  cycle_count = 0;
   bit  sink_idle_on = 1'b1;
   bit  src_idle_on = 1'b1;
   int  hold_off_cycles = 0;

   triangle_plane_clipper u_top (.*);

   always #5 clock = ~clock;

   // end the run at a generous limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // signed distance of one vertex in Q.30
   function automatic longint plane_dist(logic signed [31:0] x, logic signed [31:0] y,
                                         logic signed [31:0] z);
      return longint'(plane_nx) * x + longint'(plane_ny) * y + longint'(plane_nz) * z
         - longint'(plane_off) * 16384;
   endfunction

   // intersection of edge P (inside) to Q (outside), one coordinate at a time
   function automatic logic [95:0] edge_cut(logic [95:0] p, longint dp,
                                            logic [95:0] q, longint dq);
      longint unsigned den, rem, frac;
      logic [95:0]     res;
      longint          pc, qc, diff, prod, sh;
      den  = longint'(dp - dq);
      rem  = dp;
      frac = 0;
      for (int i = 0; i < FracBits; i++) begin
         rem  = rem << 1;
         frac = frac << 1;
         if (rem >= den) begin
            rem  = rem - den;
            frac = frac | 1;
         end
      end
      for (int k = 0; k < 3; k++) begin
         pc   = longint'(signed'(p[32*k +: 32]));
         qc   = longint'(signed'(q[32*k +: 32]));
         diff = qc - pc;
         prod = diff * longint'(frac) + (longint'(1) << 29);
         sh   = prod >>> FracBits;
         res[32*k +: 32] = 32'(pc + sh);
      end
      return res;
   endfunction

   // append one expected triangle
   function automatic void add_expected(logic [DataWidth-1:0] data, logic last);
      tri_out_type item;
      item.data = data;
      item.last = last;
      clipped_q.insert(clipped_q.size(), item);
   endfunction

   // work out the clipped triangles of one accepted triangle
   task automatic predict_clip(logic [DataWidth-1:0] d);
      logic [95:0] v[3];
      logic [95:0] c0, c1;
      longint      vdist[3];
      int          ins[3], outs[3];
      int          n_in, n_out;
      logic [23:0] col;
      col   = d[9*32 +: 24];
      n_in  = 0;
      n_out = 0;
      for (int i = 0; i < 3; i++) begin
         v[i] = d[96*i +: 96];
         vdist[i] = plane_dist(v[i][31:0], v[i][63:32], v[i][95:64]);
         if (vdist[i] >= 0) begin
            ins[n_in] = i;
            n_in++;
         end else begin
            outs[n_out] = i;
            n_out++;
         end
      end
      if (n_in == 3) begin
         add_expected({col, v[2], v[1], v[0]}, 1'b1);
      end else if (n_in == 1) begin
         c0 = edge_cut(v[ins[0]], vdist[ins[0]], v[outs[0]], vdist[outs[0]]);
         c1 = edge_cut(v[ins[0]], vdist[ins[0]], v[outs[1]], vdist[outs[1]]);
         add_expected({col, c1, c0, v[ins[0]]}, 1'b1);
      end else if (n_in == 2) begin
         c0 = edge_cut(v[ins[0]], vdist[ins[0]], v[outs[0]], vdist[outs[0]]);
         c1 = edge_cut(v[ins[1]], vdist[ins[1]], v[outs[0]], vdist[outs[0]]);
         add_expected({col, c0, v[ins[1]], v[ins[0]]}, 1'b0);
         add_expected({col, c1, c0, v[ins[1]]}, 1'b1);
      end
   endtask

   // receiver: random stalls plus a requested hold-off
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !sink_idle_on || ($urandom_range(99) >= 31);
      end
   end

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      tri_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (clipped_q.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected triangle %h last %b", rsp_tdata, rsp_tlast);
         end else begin
            want = clipped_q[0];
            clipped_q.delete(0);
            for (int f = 0; f < 9; f++) begin
               if (rsp_tdata[32*f +: 32] !== want.data[32*f +: 32]) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("field %0d: expected %h got %h", f,
                              want.data[32*f +: 32], rsp_tdata[32*f +: 32]);
               end
            end
            if (rsp_tdata[288 +: 24] !== want.data[288 +: 24]) begin
               error_count++;
               if (error_count <= 10)
                  $display("colour: expected %h got %h",
                           want.data[288 +: 24], rsp_tdata[288 +: 24]);
            end
            if (rsp_tlast !== want.last) begin
               error_count++;
               if (error_count <= 10)
                  $display("tlast: expected %b got %b", want.last, rsp_tlast);
            end
         end
      end
   end

   // offer one triangle and hold it until accepted; valid stays up for the next
   task automatic send_triangle(logic [DataWidth-1:0] d);
      while (src_idle_on && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_clip(d);
   endtask

   // drop valid and wait for every expected result
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (clipped_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(logic [CsrIdxWidth-1:0] idx, logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_NORMAL_X:     plane_nx  = val[15:0];
         CSR_NORMAL_Y:     plane_ny  = val[15:0];
         CSR_NORMAL_Z:     plane_nz  = val[15:0];
         CSR_PLANE_OFFSET: plane_off = val;
         default: ;
      endcase
   endtask

   task automatic set_plane(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                            logic [31:0] off);
      write_csr(CSR_NORMAL_X, {16'h0, nx});
      write_csr(CSR_NORMAL_Y, {16'h0, ny});
      write_csr(CSR_NORMAL_Z, {16'h0, nz});
      write_csr(CSR_PLANE_OFFSET, off);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0:       return $urandom();
         1:       return 32'($signed($urandom_range(40)) - 20) <<< 16;
         2:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(131072 * 8)) - 131072 * 4);
      endcase
   endfunction

   function automatic logic [DataWidth-1:0] rand_triangle();
      logic [DataWidth-1:0] d;
      for (int f = 0; f < 9; f++) d[32*f +: 32] = rand_coord();
      d[9*32 +: 24] = $urandom();
      return d;
   endfunction

   function automatic logic [DataWidth-1:0] make_tri(int az, int bz, int cz);
      logic [DataWidth-1:0] d;
      d = rand_triangle();
      d[64 +: 32]  = az;
      d[160 +: 32] = bz;
      d[256 +: 32] = cz;
      return d;
   endfunction

   // directed: each inside/outside pattern and the coordinate extremes
   task automatic test_directed();
      logic [DataWidth-1:0] d;
      for (int m = 0; m < 8; m++)
         send_triangle(make_tri(m[0] ? 32'sh10000 : -32'sh10000,
                                m[1] ? 32'sh10000 : -32'sh10000,
                                m[2] ? 32'sh10000 : -32'sh10000));
      // vertex exactly on the plane counts as inside
      send_triangle(make_tri(6554, -32'sh10000, -32'sh20000));
      send_triangle(make_tri(6553, 6554, -32'sh20000));
      d = {24'hFFFFFF, {9{32'h7FFF_FFFF}}};
      send_triangle(d);
      d = {24'h000000, {9{32'h8000_0000}}};
      send_triangle(d);
      send_triangle(make_tri(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
      send_triangle(make_tri(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
      drain_results();
   endtask

   // extreme and out-of-range normals
   task automatic test_plane_extremes();
      set_plane(16'h8000, 16'h7FFF, 16'h4000, 32'h8000_0000);
      repeat (8) send_triangle(rand_triangle());
      drain_results();
      set_plane(16'hC000, 16'h0000, 16'h0000, 32'h7FFF_FFFF);
      repeat (8) send_triangle(rand_triangle());
      drain_results();
   endtask

   // random triangles over random planes
   task automatic test_random(int n);
      logic [15:0] nx;
      for (int i = 0; i < n; i++) begin
         if (i % 60 == 0) begin
            drain_results();
            nx = 16'($urandom_range(32768) - 16384);
            set_plane(nx, 16'($urandom_range(32768) - 16384),
                      16'($urandom_range(32768) - 16384),
                      $urandom_range(3) == 0 ? $urandom() : 32'($signed($urandom_range(8, 0)) << 16));
            if (i % 180 == 0) write_csr(CSR_UNUSED, $urandom());
         end
         sink_idle_on = !(i >= 300 && i < 360);
         src_idle_on  = sink_idle_on;
         send_triangle(rand_triangle());
      end
      drain_results();
   endtask

   // long receiver hold-off while the sender keeps offering
   task automatic test_backpressure();
      set_plane(16'h0, 16'h0, 16'h4000, 32'h0);
      hold_off_cycles = 300;
      src_idle_on = 1'b0;
      repeat (30) send_triangle(make_tri($urandom_range(1) ? 32'sh10000 : -32'sh10000,
                                         32'sh10000, -32'sh10000));
      src_idle_on = 1'b1;
      drain_results();
   endtask

   initial begin
      plane_nx  = NormalXReset;
      plane_ny  = NormalYReset;
      plane_nz  = NormalZReset;
      plane_off = OffsetReset;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_plane_extremes();
      test_backpressure();
      test_random(590);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
